FILE: rtl/accel_tilt_angle_defines.svh
// Assertion macros shared by the tilt angle RTL.
// Used by accel_tilt_angle.sv; needs nothing else.
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ATA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tilt angle check failed");

// Next-cycle implication, disabled while in reset.
`define ATA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tilt angle check failed");

`endif

FILE: rtl/ata_pkg.sv
// Types, constants and the arctangent table for the tilt angle pipeline.
// No dependencies.
`default_nettype none

package ata_pkg;

    localparam int ROOT_STEPS  = 17;   // one stage per result bit of the square root
    localparam int ROOT_W      = 34;   // remainder / partial root width
    localparam int PRESCALE    = 16;
    localparam int CW          = 37;   // CORDIC vector width, covers gain growth
    localparam int ACC_W       = 25;   // angle accumulator, degrees Q16

    localparam logic signed [7:0] DEG_LIMIT = 8'sd90;
    localparam logic [8:0]        TRUNC_GUARD = 9'd128;

    // configuration register indexes
    localparam logic REG_MIN_ANGLE = 1'b0;
    localparam logic REG_MAX_ANGLE = 1'b1;

    typedef struct packed {
        logic              special;   // root is zero: angle decided by sign of x
        logic signed [7:0] deg;
    } side_t;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic signed [ACC_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ata_isqrt.sv
// Pipelined integer square root of a 33-bit sum, one result bit per stage.
// Depends on ata_pkg. Carries the X sample alongside.
`default_nettype none

module ata_isqrt
    import ata_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [32:0]        in_sum,
    input  wire logic signed [15:0] in_x,
    output logic                    out_valid,
    output logic [16:0]             out_root,
    output logic signed [15:0]      out_x
);

    logic [ROOT_W-1:0]   rem_reg [0:ROOT_STEPS];
    logic [ROOT_W-1:0]   res_reg [0:ROOT_STEPS];
    logic signed [15:0]  x_reg   [0:ROOT_STEPS];
    logic                vld_reg [0:ROOT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, in_sum};
            res_reg[0] <= '0;
            x_reg[0]   <= in_x;
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [ROOT_W-1:0] trial;
        logic [ROOT_W-1:0] rem_next;
        logic [ROOT_W-1:0] res_next;

        always_comb begin
            trial = res_reg[k] + BIT;
            if (rem_reg[k] >= trial) begin
                rem_next = rem_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + BIT;
            end else begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                x_reg[k+1]   <= x_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STEPS];
    assign out_root  = res_reg[ROOT_STEPS][16:0];
    assign out_x     = x_reg[ROOT_STEPS];

endmodule

`default_nettype wire

FILE: rtl/ata_cordic.sv
// Pipelined vectoring CORDIC, one rotation per stage, angle in degrees Q16.
// Depends on ata_pkg for widths, side_t and the arctangent table.
`default_nettype none

module ata_cordic
    import ata_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [16:0]             in_root,
    input  wire logic signed [15:0]      in_x,
    input  wire side_t                   in_side,
    output logic                         out_valid,
    output logic signed [ACC_W-1:0]      out_acc,
    output side_t                        out_side
);

    logic signed [CW-1:0]    cx_reg   [0:STEPS];
    logic signed [CW-1:0]    cy_reg   [0:STEPS];
    logic signed [ACC_W-1:0] acc_reg  [0:STEPS];
    side_t                   side_reg [0:STEPS];
    logic                    vld_reg  [0:STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    // scale both operands up by the prescale
    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0]   <= CW'({in_root, {PRESCALE{1'b0}}});
            cy_reg[0]   <= {{(CW-16-PRESCALE){in_x[15]}}, in_x, {PRESCALE{1'b0}}};
            acc_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        localparam logic [4:0] IDX = 5'(i);
        logic signed [CW-1:0]    dx;
        logic signed [CW-1:0]    dy;
        logic signed [ACC_W-1:0] ang;
        logic signed [CW-1:0]    cx_next;
        logic signed [CW-1:0]    cy_next;
        logic signed [ACC_W-1:0] acc_next;

        always_comb begin
            dx  = cy_reg[i] >>> i;
            dy  = cx_reg[i] >>> i;
            ang = atan_q16(IDX);
            if (!cy_reg[i][CW-1]) begin
                cx_next  = cx_reg[i] + dx;
                cy_next  = cy_reg[i] - dy;
                acc_next = acc_reg[i] + ang;
            end else begin
                cx_next  = cx_reg[i] - dx;
                cy_next  = cy_reg[i] + dy;
                acc_next = acc_reg[i] - ang;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[i+1]   <= cx_next;
                cy_reg[i+1]   <= cy_next;
                acc_reg[i+1]  <= acc_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_acc   = acc_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_angle.sv
// Tilt angle from one accelerometer reading: atan2(x, sqrt(y*y + z*z)).
// Top level; uses ata_pkg, ata_isqrt, ata_cordic and the assertion macros.
//
// Usage:
//   Input channel s_valid/s_ready carries s_accel_x, s_accel_y, s_accel_z
//   (signed 16 bit). Result channel m_valid/m_ready carries m_tilt_degrees,
//   signed whole degrees truncated toward zero, clamped to min_angle then
//   max_angle. The cfg_we/cfg_index/cfg_wdata port writes the limits
//   (index 0 = min_angle, index 1 = max_angle); write only while idle.
// Pipeline: the input register loads at the accepting edge, then come the
//   square stage, 18 square-root stages, CORDIC_STEPS + 1 CORDIC stages,
//   degree conversion and the clamp/output register.
// Throughput: one reading per cycle except during a stall; every stage is a fixed register stage.
// Reset: empties the pipeline (all valid bits low), limits go to -90 / 90.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
//   s_ready is low; nothing is dropped or repeated.
`default_nettype none
`include "accel_tilt_angle_defines.svh"

module accel_tilt_angle
    import ata_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_accel_x,
    input  wire logic signed [15:0] s_accel_y,
    input  wire logic signed [15:0] s_accel_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [7:0]       m_tilt_degrees,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_wdata
);

    logic                      en;
    logic signed [7:0]         min_angle_reg;
    logic signed [7:0]         max_angle_reg;

    logic                      in_valid_reg;
    logic signed [15:0]        x_in_reg;
    logic signed [15:0]        y_in_reg;
    logic signed [15:0]        z_in_reg;

    logic                      sq_valid_reg;
    logic signed [15:0]        x_sq_reg;
    logic [31:0]               yy_reg;
    logic [31:0]               zz_reg;
    logic signed [31:0]        yy_next;
    logic signed [31:0]        zz_next;
    logic [32:0]               sum;

    logic                      rt_valid;
    logic [16:0]               rt_root;
    logic signed [15:0]        rt_x;
    side_t                     rt_side;

    logic                      cd_valid;
    logic signed [ACC_W-1:0]   cd_acc;
    side_t                     cd_side;

    logic signed [ACC_W:0]     acc_g;
    logic [ACC_W:0]            acc_mag;
    logic [ACC_W-PRESCALE:0]   mag_int;
    logic [7:0]                deg_mag;
    logic signed [7:0]         conv_next;
    logic                      conv_valid_reg;
    logic signed [7:0]         conv_deg_reg;

    logic signed [7:0]         lo_clamped;
    logic signed [7:0]         out_next;
    logic                      m_valid_reg;
    logic signed [7:0]         m_tilt_reg;

    // advance every stage together when the output can move
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg <= -DEG_LIMIT;
            max_angle_reg <= DEG_LIMIT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_ANGLE: min_angle_reg <= cfg_wdata;
                REG_MAX_ANGLE: max_angle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_in_reg <= s_accel_x;
            y_in_reg <= s_accel_y;
            z_in_reg <= s_accel_z;
        end
    end

    // squares
    assign yy_next = y_in_reg * y_in_reg;
    assign zz_next = z_in_reg * z_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (en) begin
            sq_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_sq_reg <= x_in_reg;
            yy_reg   <= yy_next;
            zz_reg   <= zz_next;
        end
    end

    assign sum = {1'b0, yy_reg} + {1'b0, zz_reg};

    ata_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid_reg),
        .in_sum    (sum),
        .in_x      (x_sq_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_x     (rt_x)
    );

    // zero root: straight up, straight down or no tilt at all
    always_comb begin
        rt_side.special = (rt_root == '0);
        if (rt_x > 16'sd0) begin
            rt_side.deg = DEG_LIMIT;
        end else if (rt_x < 16'sd0) begin
            rt_side.deg = -DEG_LIMIT;
        end else begin
            rt_side.deg = '0;
        end
    end

    ata_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt_valid),
        .in_root   (rt_root),
        .in_x      (rt_x),
        .in_side   (rt_side),
        .out_valid (cd_valid),
        .out_acc   (cd_acc),
        .out_side  (cd_side)
    );

    // push away from zero by the guard, truncate toward zero, saturate
    always_comb begin
        if (cd_acc > 0) begin
            acc_g = (ACC_W+1)'(cd_acc) + (ACC_W+1)'(TRUNC_GUARD);
        end else if (cd_acc < 0) begin
            acc_g = (ACC_W+1)'(cd_acc) - (ACC_W+1)'(TRUNC_GUARD);
        end else begin
            acc_g = '0;
        end
        acc_mag = acc_g[ACC_W] ? (ACC_W+1)'(-acc_g) : acc_g;
        mag_int = acc_mag[ACC_W:PRESCALE];
        if (mag_int > (ACC_W-PRESCALE+1)'(DEG_LIMIT)) begin
            deg_mag = DEG_LIMIT;
        end else begin
            deg_mag = mag_int[7:0];
        end
        if (cd_side.special) begin
            conv_next = cd_side.deg;
        end else if (acc_g[ACC_W]) begin
            conv_next = -deg_mag;
        end else begin
            conv_next = deg_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_valid_reg <= 1'b0;
        end else if (en) begin
            conv_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            conv_deg_reg <= conv_next;
        end
    end

    // lower limit first, upper limit wins
    always_comb begin
        lo_clamped = (conv_deg_reg < min_angle_reg) ? min_angle_reg : conv_deg_reg;
        out_next   = (lo_clamped > max_angle_reg) ? max_angle_reg : lo_clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= conv_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tilt_reg <= out_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tilt_degrees = m_tilt_reg;

    `ATA_ASSERT_NOW(a_conv_range, aclk, aresetn, conv_valid_reg, (conv_deg_reg >= -DEG_LIMIT) && (conv_deg_reg <= DEG_LIMIT))
    `ATA_ASSERT_NOW(a_clamp_limits, aclk, aresetn, m_valid_reg && (min_angle_reg <= max_angle_reg), (m_tilt_reg >= min_angle_reg) && (m_tilt_reg <= max_angle_reg))
    `ATA_ASSERT_NEXT(a_stall_freeze, aclk, aresetn, !s_ready, $stable(conv_deg_reg) && $stable(conv_valid_reg))

endmodule

`default_nettype wire
